// ===== hdl/pmc_pkg.sv =====
package pmc_pkg;

  localparam int unsigned ENTRIES      = 4;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned REG_ADDR_LSB = 2;
  localparam int unsigned PHYS_ADDR_W  = 38;
  localparam int unsigned LEN_W        = 17;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned SLOT_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned MASK_W       = ENTRIES;
  localparam int unsigned OFFSET_W     = 16;
  localparam int unsigned SHIFT_W      = 5;
  localparam int unsigned AGE_W        = 8;

  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MIN = 5'd12;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX = 5'd16;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;
  localparam logic [AGE_W-1:0]   AGE_LIMIT_RST  = 8'd2;

  typedef enum logic [0:0] {
    REG_PAGE_SHIFT = 1'b0,
    REG_AGE_LIMIT  = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic                   evict_valid;
    logic [PHYS_ADDR_W-1:0] evicted_page;
    logic [MASK_W-1:0]      expired_mask;
    logic [OFFSET_W-1:0]    in_page_off;
    logic [LEN_W-1:0]       clamped_length;
  } resp_t;

endpackage

// ===== hdl/pmc_req_if.sv =====
interface pmc_req_if;
  logic                            valid;
  logic                            ready;
  logic [pmc_pkg::PHYS_ADDR_W-1:0] byte_addr;
  logic [pmc_pkg::LEN_W-1:0]       req_length;
  logic [pmc_pkg::TIME_W-1:0]      now_seconds;

  modport source (output valid, byte_addr, req_length, now_seconds, input ready);
  modport sink   (input valid, byte_addr, req_length, now_seconds, output ready);
endinterface

// ===== hdl/pmc_resp_if.sv =====
interface pmc_resp_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [pmc_pkg::SLOT_W-1:0]      slot;
  logic                            evict_valid;
  logic [pmc_pkg::PHYS_ADDR_W-1:0] evicted_page;
  logic [pmc_pkg::MASK_W-1:0]      expired_mask;
  logic [pmc_pkg::OFFSET_W-1:0]    in_page_off;
  logic [pmc_pkg::LEN_W-1:0]       clamped_length;

  modport source (output valid, hit, slot, evict_valid, evicted_page, expired_mask,
                  in_page_off, clamped_length, input ready);
  modport sink   (input valid, hit, slot, evict_valid, evicted_page, expired_mask,
                  in_page_off, clamped_length, output ready);
endinterface

// ===== hdl/page_mapping_cache_with_expiry.sv =====
// Lookup: the table memory is read one entry per cycle, from entry 0 up to the hit entry
// (up to the last entry on a miss), and the result is registered after that scan, once
// any earlier result has been taken; the table is written once per request. A new
// request is accepted only after the block has returned to idle with its result written.
// Reset (rst, synchronous) clears all valid bits and the result valid flag, and sets
// the page shift to 12 and age_limit to 2; there is no clearing pass over the memory.
module page_mapping_cache_with_expiry #(
  parameter int unsigned ADDR_BITS = 38
) (
  input  logic                          clk,
  input  logic                          rst,
  pmc_req_if.sink                       req,
  pmc_resp_if.source                    resp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmc_pkg::PADDR_W-1:0]   paddr,
  input  logic [pmc_pkg::DATA_W-1:0]    pwdata,
  output logic [pmc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import pmc_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [ADDR_BITS-1:0] page;
    logic [TIME_W-1:0]    stamp;
  } entry_t;

  // Configuration registers
  logic [SHIFT_W-1:0] pg_shift;
  logic [AGE_W-1:0]   age_limit;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[REG_ADDR_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pg_shift  <= PAGE_SHIFT_RST;
      age_limit <= AGE_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAGE_SHIFT: pg_shift  <= pwdata[SHIFT_W-1:0];
        REG_AGE_LIMIT:  age_limit <= pwdata[AGE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAGE_SHIFT: prdata = DATA_W'(pg_shift);
      REG_AGE_LIMIT:  prdata = DATA_W'(age_limit);
    endcase
  end

  // Request decode: page, in-page offset and clamped length
  logic [SHIFT_W-1:0]   shift_eff;
  logic [LEN_W-1:0]     offset_mask;
  logic [63:0]          addr_ext;
  logic [ADDR_BITS-1:0] addr_w;
  logic [LEN_W-1:0]     req_offset;
  logic [LEN_W-1:0]     room;
  logic [ADDR_BITS-1:0] req_page;
  logic [LEN_W-1:0]     req_len_c;

  always_comb begin
    if (pg_shift < PAGE_SHIFT_MIN) begin
      shift_eff = PAGE_SHIFT_MIN;
    end else if (pg_shift > PAGE_SHIFT_MAX) begin
      shift_eff = PAGE_SHIFT_MAX;
    end else begin
      shift_eff = pg_shift;
    end
    offset_mask = (LEN_W'(1) << shift_eff) - LEN_W'(1);
    addr_ext    = 64'(req.byte_addr);
    addr_w      = addr_ext[ADDR_BITS-1:0];
    req_offset  = addr_w[LEN_W-1:0] & offset_mask;
    req_page    = addr_w & ~ADDR_BITS'(offset_mask);
    room        = offset_mask - req_offset + LEN_W'(1);
    req_len_c   = (req.req_length > room) ? room : req.req_length;
  end

  // Table memory: page and timestamp per entry, valid bits in flip-flops
  entry_t             mem [ENTRIES];
  entry_t             rd_entry;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_entry;
  logic [ENTRIES-1:0] valid, valid_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  // Scan state
  state_t               state, state_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic                 hit, hit_next;
  logic [IDX_W-1:0]     slot_idx, slot_idx_next;
  logic                 free_found, free_found_next;
  logic [IDX_W-1:0]     free_idx, free_idx_next;
  logic [IDX_W-1:0]     lru_idx, lru_idx_next;
  logic [TIME_W-1:0]    oldest_age, oldest_age_next;
  logic [ADDR_BITS-1:0] oldest_page, oldest_page_next;
  logic [ENTRIES-1:0]   expired, expired_next;
  logic [ADDR_BITS-1:0] cur_page, cur_page_next;
  logic [TIME_W-1:0]    cur_now, cur_now_next;
  logic [OFFSET_W-1:0]  cur_offset, cur_offset_next;
  logic [LEN_W-1:0]     cur_len, cur_len_next;
  logic                 out_valid, out_valid_next;
  resp_t                out_reg, out_next;

  logic [TIME_W-1:0]    age;
  logic                 ent_valid;
  logic                 ent_hit;
  logic [IDX_W-1:0]     slot_sel;
  logic                 evict;
  logic [63:0]          evict_ext;

  assign age       = cur_now - rd_entry.stamp;
  assign ent_valid = valid[idx];
  assign ent_hit   = ent_valid && (rd_entry.page == cur_page);
  assign evict_ext = 64'(oldest_page);

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    hit_next         = hit;
    slot_idx_next    = slot_idx;
    free_found_next  = free_found;
    free_idx_next    = free_idx;
    lru_idx_next     = lru_idx;
    oldest_age_next  = oldest_age;
    oldest_page_next = oldest_page;
    expired_next     = expired;
    cur_page_next    = cur_page;
    cur_now_next     = cur_now;
    cur_offset_next  = cur_offset;
    cur_len_next     = cur_len;
    valid_next       = valid;
    out_valid_next   = out_valid && !resp.ready;
    out_next         = out_reg;
    req.ready        = (state == ST_IDLE);
    rd_addr          = '0;
    mem_we           = 1'b0;
    wr_addr          = '0;
    wr_entry         = '{page: cur_page, stamp: cur_now};
    slot_sel         = hit ? slot_idx : (free_found ? free_idx : lru_idx);
    evict            = !hit && !free_found && valid[lru_idx];

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next       = ST_SCAN;
          idx_next         = '0;
          hit_next         = 1'b0;
          slot_idx_next    = '0;
          free_found_next  = 1'b0;
          free_idx_next    = '0;
          lru_idx_next     = '0;
          oldest_age_next  = '0;
          oldest_page_next = '0;
          expired_next     = '0;
          cur_page_next    = req_page;
          cur_now_next     = req.now_seconds;
          cur_offset_next  = req_offset[OFFSET_W-1:0];
          cur_len_next     = req_len_c;
        end
      end

      ST_SCAN: begin
        rd_addr = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
        if (ent_hit) begin
          hit_next      = 1'b1;
          slot_idx_next = idx;
          state_next    = ST_DONE;
        end else begin
          if (ent_valid) begin
            // Entry 0 seeds the oldest tracker so its page is known if it is evicted.
            if ((age > oldest_age) || (idx == '0)) begin
              oldest_age_next  = age;
              lru_idx_next     = idx;
              oldest_page_next = rd_entry.page;
            end
            if (age > TIME_W'(age_limit)) begin
              expired_next[idx] = 1'b1;
              free_found_next   = 1'b1;
              free_idx_next     = idx;
            end
          end else if (!free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = idx;
          end
          if (idx == LAST_IDX) begin
            state_next = ST_DONE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (!out_valid || resp.ready) begin
          mem_we     = 1'b1;
          wr_addr    = slot_sel;
          valid_next = valid & ~expired;
          if (!hit) begin
            valid_next[slot_sel] = 1'b1;
          end
          out_valid_next          = 1'b1;
          out_next.hit            = hit;
          out_next.slot           = SLOT_W'(slot_sel);
          out_next.evict_valid    = evict;
          out_next.evicted_page   = evict ? evict_ext[PHYS_ADDR_W-1:0] : '0;
          out_next.expired_mask   = MASK_W'(expired);
          out_next.in_page_off    = cur_offset;
          out_next.clamped_length = cur_len;
          state_next              = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    hit         <= hit_next;
    slot_idx    <= slot_idx_next;
    free_found  <= free_found_next;
    free_idx    <= free_idx_next;
    lru_idx     <= lru_idx_next;
    oldest_age  <= oldest_age_next;
    oldest_page <= oldest_page_next;
    expired     <= expired_next;
    cur_page    <= cur_page_next;
    cur_now     <= cur_now_next;
    cur_offset  <= cur_offset_next;
    cur_len     <= cur_len_next;
    out_reg     <= out_next;
  end

  assign resp.valid          = out_valid;
  assign resp.hit            = out_reg.hit;
  assign resp.slot           = out_reg.slot;
  assign resp.evict_valid    = out_reg.evict_valid;
  assign resp.evicted_page   = out_reg.evicted_page;
  assign resp.expired_mask   = out_reg.expired_mask;
  assign resp.in_page_off    = out_reg.in_page_off;
  assign resp.clamped_length = out_reg.clamped_length;

endmodule

// ===== hdl/pmc_checker.sv =====
module pmc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            resp_valid,
  input logic                            resp_ready,
  input logic                            hit,
  input logic                            evict_valid,
  input logic [pmc_pkg::PHYS_ADDR_W-1:0] evicted_page,
  input logic [pmc_pkg::MASK_W-1:0]      expired_mask
);

  a_resp_held: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("result dropped before it was taken");

  // A hit never replaces anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    resp_valid && hit |-> !evict_valid)
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !evict_valid |-> evicted_page == '0)
    else $error("evicted page nonzero without an eviction");

  // An expired entry becomes the free slot, so no live entry may be replaced as well.
  a_evict_no_expiry: assert property (@(posedge clk) disable iff (rst)
    resp_valid && evict_valid |-> expired_mask == '0)
    else $error("eviction reported together with expired entries");

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while a lookup is in progress");

endmodule

bind page_mapping_cache_with_expiry pmc_checker u_pmc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .resp_valid   (resp.valid),
  .resp_ready   (resp.ready),
  .hit          (resp.hit),
  .evict_valid  (resp.evict_valid),
  .evicted_page (resp.evicted_page),
  .expired_mask (resp.expired_mask)
);
